/* rtl/csph_pkg.sv */
`default_nettype none

package csph_pkg;

    localparam int MAX_RADIUS_DEF   = 128;
    localparam int ANGLE_STAGES_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam int PIX_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int RADIUS_W   = 8;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ANG_W      = 33;

    localparam int SQ_FRAC     = 16;
    localparam int Z14_SHIFT   = 6;
    localparam int LAT_SHIFT   = 16;
    localparam int LAT_TOP_EXP = 30;
    localparam int BAND_BIT    = 28;
    localparam int LIGHT_SHIFT = 8;
    localparam int DEN_SHIFT   = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 3'd0,
        REG_TILT_COS = 3'd1,
        REG_TILT_SIN = 3'd2,
        REG_SPIN_COS = 3'd3,
        REG_SPIN_SIN = 3'd4
    } cfg_reg_t;

    localparam logic [RADIUS_W-1:0]      RADIUS_RST   = 8'd100;
    localparam logic signed [TRIG_W-1:0] TILT_COS_RST = 16'sd15833;
    localparam logic signed [TRIG_W-1:0] TILT_SIN_RST = -16'sd4212;
    localparam logic signed [TRIG_W-1:0] SPIN_COS_RST = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SPIN_SIN_RST = 16'sd0;

    localparam logic [CHAN_W-1:0] BASE_RED   = 8'd216;
    localparam logic [CHAN_W-1:0] BASE_WHITE = 8'd255;

    localparam logic [29:0] LAT_EDGE_1 = 30'd410903207;
    localparam logic [29:0] LAT_EDGE_2 = 30'd759250125;
    localparam logic [29:0] LAT_EDGE_3 = 30'd992008094;

    localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 33'sd2147483648;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER   = 33'sd1073741824;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

endpackage

`default_nettype wire

/* rtl/csph_sqrt.sv */
`default_nettype none

module csph_sqrt #(
    parameter int RAD_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RT_W = RAD_W / 2;
    localparam int EW   = RAD_W + 2;

    logic [EW-1:0]     rem_reg   [RT_W];
    logic [RT_W-1:0]   root_reg  [RT_W];
    logic [SIDE_W-1:0] side_reg  [RT_W];
    logic [EW-1:0]     rem_next  [RT_W];
    logic [RT_W-1:0]   root_next [RT_W];
    logic [SIDE_W-1:0] side_next [RT_W];
    logic [RT_W-1:0]   valid_reg;

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        localparam int B = RT_W - 1 - k;
        logic [EW-1:0]   rem_in;
        logic [EW-1:0]   trial;
        logic [RT_W-1:0] root_in;
        if (k == 0) begin : g_first
            assign rem_in       = EW'(in_rad);
            assign root_in      = '0;
            assign side_next[k] = in_side;
        end
        else begin : g_rest
            assign rem_in       = rem_reg[k-1];
            assign root_in      = root_reg[k-1];
            assign side_next[k] = side_reg[k-1];
        end
        assign trial        = (EW'(root_in) << (B + 1)) + (EW'(1) << (2 * B));
        assign rem_next[k]  = (rem_in >= trial) ? rem_in - trial : rem_in;
        assign root_next[k] = (rem_in >= trial) ? (root_in | (RT_W'(1) << B)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[RT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_side  = side_reg[RT_W-1];

endmodule

`default_nettype wire

/* rtl/csph_cordic.sv */
`default_nettype none

module csph_cordic #(
    parameter int DW     = 42,
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [DW-1:0]              in_y,
    input  logic signed [DW-1:0]              in_x,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [csph_pkg::ANG_W-1:0] out_angle,
    output logic [SIDE_W-1:0]                 out_side
);

    import csph_pkg::*;

    localparam int IW = DW + 2;
    localparam int NS = STAGES + 1;

    logic signed [IW-1:0]    x_reg    [NS];
    logic signed [IW-1:0]    y_reg    [NS];
    logic signed [ANG_W-1:0] acc_reg  [NS];
    logic [SIDE_W-1:0]       side_reg [NS];
    logic signed [IW-1:0]    x_next   [NS];
    logic signed [IW-1:0]    y_next   [NS];
    logic signed [ANG_W-1:0] acc_next [NS];
    logic [SIDE_W-1:0]       side_next[NS];
    logic [NS-1:0]           zero_reg;
    logic [NS-1:0]           zero_next;
    logic [NS-1:0]           valid_reg;

    logic signed [IW-1:0] xe;
    logic signed [IW-1:0] ye;

    assign xe = IW'(in_x);
    assign ye = IW'(in_y);

    always_comb
    begin
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                x_next[0]   = ye;
                y_next[0]   = -xe;
                acc_next[0] = ANG_QUARTER;
            end
            else
            begin
                x_next[0]   = -ye;
                y_next[0]   = xe;
                acc_next[0] = -ANG_QUARTER;
            end
        end
        else
        begin
            x_next[0]   = xe;
            y_next[0]   = ye;
            acc_next[0] = '0;
        end
    end

    assign zero_next[0] = (in_x == '0) && (in_y == '0);
    assign side_next[0] = in_side;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [IW-1:0] dx;
        logic signed [IW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign x_next[i+1]   = (y_reg[i] >= 0) ? x_reg[i] + dx : x_reg[i] - dx;
        assign y_next[i+1]   = (y_reg[i] >= 0) ? y_reg[i] - dy : y_reg[i] + dy;
        assign acc_next[i+1] = (y_reg[i] >= 0) ? acc_reg[i] + ATAN_TAB[i]
                                               : acc_reg[i] - ATAN_TAB[i];
        assign zero_next[i+1] = zero_reg[i];
        assign side_next[i+1] = side_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= zero_next;
            for (int k = 0; k < NS; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                acc_reg[k]  <= acc_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_angle = zero_reg[NS-1] ? '0 : acc_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

`default_nettype wire

/* rtl/checkered_sphere_shader_top.sv */
// Throughput: one pixel request per cycle while the output is not stalled; the square
// root, the angle unit and the color divider are pipelines of one result bit or one
// rotation per stage. A stall on the output holds every stage in place.
// Reset clears all valid bits and loads the registers with their default values.
`default_nettype none

module checkered_sphere_shader_top #(
    parameter int MAX_RADIUS   = csph_pkg::MAX_RADIUS_DEF,
    parameter int ANGLE_STAGES = csph_pkg::ANGLE_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [csph_pkg::PIX_W-1:0]      pixel_col,
    input  logic [csph_pkg::PIX_W-1:0]      pixel_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res,
    output logic [csph_pkg::CHAN_W-1:0]     red,
    output logic [csph_pkg::CHAN_W-1:0]     green,
    output logic [csph_pkg::CHAN_W-1:0]     blue,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csph_pkg::CFG_DATA_W-1:0] cfg_data
);

    import csph_pkg::*;

    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int CW    = (RW > RADIUS_W) ? RW : RADIUS_W;
    localparam int BW    = (((RW + 1) > PIX_W) ? (RW + 1) : PIX_W) + 1;
    localparam int XW    = RW + 1;
    localparam int ZW    = RW + 8;
    localparam int RAD_W = 2 * ZW;
    localparam int PW1   = XW + TRIG_W;
    localparam int X1W   = PW1 + 1;
    localparam int SPW   = X1W + TRIG_W + 1;
    localparam int LW    = X1W + LAT_SHIFT + 1;
    localparam int THW   = RW + 30;
    localparam int NUMW  = RW + 9;
    localparam int NW    = NUMW + CHAN_W;
    localparam int QS    = CHAN_W;
    localparam int SQ_SIDE_W = 1 + 2 * XW;
    localparam int CO_SIDE_W = 2 + ZW;

    logic [RADIUS_W-1:0]      radius_reg;
    logic signed [TRIG_W-1:0] tilt_cos_reg;
    logic signed [TRIG_W-1:0] tilt_sin_reg;
    logic signed [TRIG_W-1:0] spin_cos_reg;
    logic signed [TRIG_W-1:0] spin_sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RST;
            tilt_cos_reg <= TILT_COS_RST;
            tilt_sin_reg <= TILT_SIN_RST;
            spin_cos_reg <= SPIN_COS_RST;
            spin_sin_reg <= SPIN_SIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RADIUS:   radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_TILT_COS: tilt_cos_reg <= cfg_data;
                REG_TILT_SIN: tilt_sin_reg <= cfg_data;
                REG_SPIN_COS: spin_cos_reg <= cfg_data;
                REG_SPIN_SIN: spin_sin_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [CW-1:0] rad_ext;
    logic [CW-1:0] rad_cap;
    logic [RW-1:0] r_sat;

    assign rad_ext = CW'(radius_reg);
    assign rad_cap = (rad_ext > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : rad_ext;
    assign r_sat   = rad_cap[RW-1:0];

    // Values that follow from the radius alone are refreshed every cycle.
    logic [2*RW-1:0] rr_reg;
    logic [THW-1:0]  th1_reg;
    logic [THW-1:0]  th2_reg;
    logic [THW-1:0]  th3_reg;

    always_ff @(posedge clk)
    begin
        rr_reg  <= (2 * RW)'(r_sat) * (2 * RW)'(r_sat);
        th1_reg <= THW'(LAT_EDGE_1) * THW'(r_sat);
        th2_reg <= THW'(LAT_EDGE_2) * THW'(r_sat);
        th3_reg <= THW'(LAT_EDGE_3) * THW'(r_sat);
    end

    logic adv;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic [BW-1:0]        col_e;
    logic [BW-1:0]        row_e;
    logic [BW-1:0]        two_r;
    logic                 a_box_next;
    logic signed [XW-1:0] a_x_next;
    logic signed [XW-1:0] a_y_next;

    assign col_e      = BW'(pixel_col);
    assign row_e      = BW'(pixel_row);
    assign two_r      = BW'(r_sat) << 1;
    assign a_box_next = (r_sat != '0) && (col_e < two_r) && (row_e < two_r);
    assign a_x_next   = XW'(col_e - BW'(r_sat));
    assign a_y_next   = XW'(row_e - BW'(r_sat));

    logic                 a_valid_reg;
    logic                 a_box_reg;
    logic signed [XW-1:0] a_x_reg;
    logic signed [XW-1:0] a_y_reg;

    logic signed [2*XW-1:0] b_xsq;
    logic signed [2*XW-1:0] b_ysq;
    logic                   b_valid_reg;
    logic                   b_box_reg;
    logic [2*RW-1:0]        b_xx_reg;
    logic [2*RW-1:0]        b_yy_reg;
    logic signed [XW-1:0]   b_x_reg;
    logic signed [XW-1:0]   b_y_reg;

    assign b_xsq = a_x_reg * a_x_reg;
    assign b_ysq = a_y_reg * a_y_reg;

    logic signed [2*RW+1:0]  c_zs;
    logic                    c_inside_next;
    logic [2*RW-1:0]         c_rad_next;
    logic                    c_valid_reg;
    logic [2*RW-1:0]         c_rad_reg;
    logic [SQ_SIDE_W-1:0]    c_side_reg;

    assign c_zs = $signed({2'b00, rr_reg}) - $signed({2'b00, b_xx_reg})
                - $signed({2'b00, b_yy_reg});
    assign c_inside_next = b_box_reg && !c_zs[2*RW+1];
    assign c_rad_next    = c_inside_next ? c_zs[2*RW-1:0] : '0;

    logic                 sq_valid;
    logic [ZW-1:0]        sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic                 sq_inside;
    logic signed [XW-1:0] sq_x;
    logic signed [XW-1:0] sq_y;

    csph_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .in_rad    ({c_rad_reg, {SQ_FRAC{1'b0}}}),
        .in_side   (c_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_inside = sq_side[2*XW];
    assign sq_x      = sq_side[2*XW-1:XW];
    assign sq_y      = sq_side[XW-1:0];

    logic signed [PW1-1:0] t1_xc;
    logic signed [PW1-1:0] t1_ys;
    logic signed [PW1-1:0] t1_xs;
    logic signed [PW1-1:0] t1_yc;
    logic                  t1_valid_reg;
    logic                  t1_inside_reg;
    logic [ZW-1:0]         t1_zq_reg;
    logic signed [PW1-1:0] t1_xc_reg;
    logic signed [PW1-1:0] t1_ys_reg;
    logic signed [PW1-1:0] t1_xs_reg;
    logic signed [PW1-1:0] t1_yc_reg;

    assign t1_xc = sq_x * tilt_cos_reg;
    assign t1_ys = sq_y * tilt_sin_reg;
    assign t1_xs = sq_x * tilt_sin_reg;
    assign t1_yc = sq_y * tilt_cos_reg;

    logic                  t2_valid_reg;
    logic                  t2_inside_reg;
    logic [ZW-1:0]         t2_zq_reg;
    logic signed [X1W-1:0] t2_x1_reg;
    logic signed [X1W-1:0] t2_y1_reg;

    logic signed [SPW-1:0] s1_xc;
    logic signed [SPW-1:0] s1_xs;
    logic signed [SPW-1:0] s1_zs_raw;
    logic signed [SPW-1:0] s1_zc_raw;
    logic signed [LW-1:0]  s1_ylhs;
    logic signed [LW-1:0]  s1_t1;
    logic signed [LW-1:0]  s1_t2;
    logic signed [LW-1:0]  s1_t3;
    logic signed [LW-1:0]  s1_ttop;
    logic [7:0]            s1_cmp;
    logic                  s1_valid_reg;
    logic                  s1_inside_reg;
    logic                  s1_vpar_reg;
    logic [ZW-1:0]         s1_zq_reg;
    logic signed [SPW-1:0] s1_xc_reg;
    logic signed [SPW-1:0] s1_xs_reg;
    logic signed [SPW-1:0] s1_zs_reg;
    logic signed [SPW-1:0] s1_zc_reg;

    assign s1_xc     = t2_x1_reg * spin_cos_reg;
    assign s1_xs     = t2_x1_reg * spin_sin_reg;
    assign s1_zs_raw = $signed({1'b0, t2_zq_reg}) * spin_sin_reg;
    assign s1_zc_raw = $signed({1'b0, t2_zq_reg}) * spin_cos_reg;

    assign s1_ylhs = LW'(t2_y1_reg) <<< LAT_SHIFT;
    assign s1_t1   = $signed(LW'(th1_reg));
    assign s1_t2   = $signed(LW'(th2_reg));
    assign s1_t3   = $signed(LW'(th3_reg));
    assign s1_ttop = $signed(LW'(r_sat) << LAT_TOP_EXP);
    assign s1_cmp  = {s1_ylhs >= -s1_t3, s1_ylhs >= -s1_t2, s1_ylhs >= -s1_t1,
                      s1_ylhs >= 0, s1_ylhs >= s1_t1, s1_ylhs >= s1_t2,
                      s1_ylhs >= s1_t3, s1_ylhs >= s1_ttop};

    logic                  s2_valid_reg;
    logic signed [SPW-1:0] s2_x2_reg;
    logic signed [SPW-1:0] s2_z2_reg;
    logic [CO_SIDE_W-1:0]  s2_side_reg;

    logic                    co_valid;
    logic signed [ANG_W-1:0] co_angle;
    logic [CO_SIDE_W-1:0]    co_side;

    csph_cordic #(
        .DW     (SPW),
        .STAGES (ANGLE_STAGES),
        .SIDE_W (CO_SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_valid_reg),
        .in_y      (s2_x2_reg),
        .in_x      (s2_z2_reg),
        .in_side   (s2_side_reg),
        .out_valid (co_valid),
        .out_angle (co_angle),
        .out_side  (co_side)
    );

    logic              e_band_odd;
    logic              e_white_next;
    logic [NUMW-1:0]   e_num;
    logic [CHAN_W-1:0] e_base;
    logic              e_valid_reg;
    logic              e_inside_reg;
    logic              e_white_reg;
    logic [NW-1:0]     e_n_reg;

    assign e_band_odd   = (co_angle > ANG_HALF_TURN || co_angle < -ANG_HALF_TURN)
                        ? 1'b0 : co_angle[BAND_BIT];
    assign e_white_next = e_band_odd ^ co_side[ZW];
    assign e_base       = e_white_next ? BASE_WHITE : BASE_RED;
    assign e_num        = (NUMW'(r_sat) << LIGHT_SHIFT) + NUMW'(co_side[ZW-1:0]);

    logic [NUMW-1:0] dv_den;
    logic [NW-1:0]   dv_rem_reg  [QS];
    logic [QS-1:0]   dv_q_reg    [QS];
    logic [NW-1:0]   dv_rem_next [QS];
    logic [QS-1:0]   dv_q_next   [QS];
    logic [QS-1:0]   dv_white_reg;
    logic [QS-1:0]   dv_inside_reg;
    logic [QS-1:0]   dv_valid_reg;

    assign dv_den = NUMW'(r_sat) << DEN_SHIFT;

    for (genvar k = 0; k < QS; k++) begin : g_div
        localparam int B = QS - 1 - k;
        logic [NW-1:0] rem_in;
        logic [QS-1:0] q_in;
        logic [NW-1:0] dsh;
        if (k == 0) begin : g_first
            assign rem_in = e_n_reg;
            assign q_in   = '0;
        end
        else begin : g_rest
            assign rem_in = dv_rem_reg[k-1];
            assign q_in   = dv_q_reg[k-1];
        end
        assign dsh            = NW'(dv_den) << B;
        assign dv_rem_next[k] = (rem_in >= dsh) ? rem_in - dsh : rem_in;
        assign dv_q_next[k]   = (rem_in >= dsh) ? (q_in | (QS'(1) << B)) : q_in;
    end

    logic              out_valid_reg;
    logic              out_inside_reg;
    logic [CHAN_W-1:0] out_red_reg;
    logic [CHAN_W-1:0] out_green_reg;
    logic [CHAN_W-1:0] out_blue_reg;
    logic [CHAN_W-1:0] q_last;

    assign q_last = dv_q_reg[QS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            t1_valid_reg  <= sq_valid;
            t2_valid_reg  <= t1_valid_reg;
            s1_valid_reg  <= t2_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            e_valid_reg   <= co_valid;
            dv_valid_reg  <= {dv_valid_reg[QS-2:0], e_valid_reg};
            out_valid_reg <= dv_valid_reg[QS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_box_reg <= a_box_next;
            a_x_reg   <= a_x_next;
            a_y_reg   <= a_y_next;

            b_box_reg <= a_box_reg;
            b_xx_reg  <= b_xsq[2*RW-1:0];
            b_yy_reg  <= b_ysq[2*RW-1:0];
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;

            c_rad_reg  <= c_rad_next;
            c_side_reg <= {c_inside_next, b_x_reg, b_y_reg};

            t1_inside_reg <= sq_inside;
            t1_zq_reg     <= sq_root;
            t1_xc_reg     <= t1_xc;
            t1_ys_reg     <= t1_ys;
            t1_xs_reg     <= t1_xs;
            t1_yc_reg     <= t1_yc;

            t2_inside_reg <= t1_inside_reg;
            t2_zq_reg     <= t1_zq_reg;
            t2_x1_reg     <= X1W'(t1_xc_reg) - X1W'(t1_ys_reg);
            t2_y1_reg     <= X1W'(t1_xs_reg) + X1W'(t1_yc_reg);

            s1_inside_reg <= t2_inside_reg;
            s1_vpar_reg   <= ^s1_cmp;
            s1_zq_reg     <= t2_zq_reg;
            s1_xc_reg     <= s1_xc;
            s1_xs_reg     <= s1_xs;
            s1_zs_reg     <= s1_zs_raw <<< Z14_SHIFT;
            s1_zc_reg     <= s1_zc_raw <<< Z14_SHIFT;

            s2_x2_reg   <= s1_xc_reg - s1_zs_reg;
            s2_z2_reg   <= s1_xs_reg + s1_zc_reg;
            s2_side_reg <= {s1_inside_reg, s1_vpar_reg, s1_zq_reg};

            e_inside_reg <= co_side[ZW+1];
            e_white_reg  <= e_white_next;
            e_n_reg      <= NW'(e_base) * NW'(e_num);

            dv_white_reg  <= {dv_white_reg[QS-2:0], e_white_reg};
            dv_inside_reg <= {dv_inside_reg[QS-2:0], e_inside_reg};
            for (int k = 0; k < QS; k++)
            begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
            end

            out_inside_reg <= dv_inside_reg[QS-1];
            out_red_reg    <= dv_inside_reg[QS-1] ? q_last : '0;
            out_green_reg  <= (dv_inside_reg[QS-1] && dv_white_reg[QS-1]) ? q_last : '0;
            out_blue_reg   <= (dv_inside_reg[QS-1] && dv_white_reg[QS-1]) ? q_last : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = out_inside_reg;
    assign red        = out_red_reg;
    assign green      = out_green_reg;
    assign blue       = out_blue_reg;

    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> red == '0 && green == '0 && blue == '0)
        else $error("Transparent pixel carries a color.");

    a_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> green == blue && (green == '0 || green == red))
        else $error("Pixel color is neither red nor white.");

    a_light_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> red >= (BASE_RED >> 1))
        else $error("Shaded red channel below half brightness.");

endmodule

`default_nettype wire

/* tb/checkered_sphere_shader_checker.sv */
`timescale 1ns / 100ps

module checkered_sphere_shader_checker
    import csph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel_col,
    input  logic [PIX_W-1:0]      pixel_row,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  inside_res,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_pixels
);

    typedef struct packed {
        logic             on_sphere;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } pixel_color_t;

    pixel_color_t expected_colors[$];

    logic [RADIUS_W-1:0]      radius_q;
    logic signed [TRIG_W-1:0] tilt_cos_q;
    logic signed [TRIG_W-1:0] tilt_sin_q;
    logic signed [TRIG_W-1:0] spin_cos_q;
    logic signed [TRIG_W-1:0] spin_sin_q;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint longitude_of(longint yv, longint xv);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t = xv; xv = yv; yv = -t; acc = 64'sd1 <<< 30;
            end
            else
            begin
                t = xv; xv = -yv; yv = t; acc = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < ANGLE_STAGES_DEF && i < ATAN_LEN; i++)
        begin
            dx = fshift(yv, i);
            dy = fshift(xv, i);
            if (yv >= 0)
            begin
                xv += dx; yv -= dy; acc += longint'(ATAN_TAB[i]);
            end
            else
            begin
                xv -= dx; yv += dy; acc -= longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic pixel_color_t shade_pixel(logic [PIX_W-1:0] c, logic [PIX_W-1:0] w);
        pixel_color_t pc;
        longint rr, x, y, zsq, zq, z14, x1, y1, x2, z2r, u, ub, vb, num, den;
        longint br, bg, bb;
        longint edges[8];
        edges = '{-longint'(LAT_EDGE_3), -longint'(LAT_EDGE_2), -longint'(LAT_EDGE_1), 0,
                  longint'(LAT_EDGE_1), longint'(LAT_EDGE_2), longint'(LAT_EDGE_3),
                  64'sd1 <<< 30};
        pc = '0;
        rr = radius_q;
        if (rr > MAX_RADIUS_DEF)
            rr = MAX_RADIUS_DEF;
        if (rr == 0 || c >= 2 * rr || w >= 2 * rr)
            return pc;
        x = longint'(c) - rr;
        y = longint'(w) - rr;
        zsq = rr * rr - x * x - y * y;
        if (zsq < 0)
            return pc;
        zq = root_floor(zsq * 65536);
        z14 = zq * 64;
        x1 = x * tilt_cos_q - y * tilt_sin_q;
        y1 = x * tilt_sin_q + y * tilt_cos_q;
        x2 = x1 * spin_cos_q - z14 * spin_sin_q;
        z2r = x1 * spin_sin_q + z14 * spin_cos_q;
        u = longitude_of(x2, z2r);
        if (u > (64'sd1 <<< 31))
            u = 64'sd1 <<< 31;
        if (u < -(64'sd1 <<< 31))
            u = -(64'sd1 <<< 31);
        ub = (u + (64'sd1 <<< 31)) >>> 28;
        vb = 0;
        for (int k = 0; k < 8; k++)
            if (y1 * 65536 >= edges[k] * rr)
                vb++;
        if (((ub + vb) & 1) == 0)
        begin
            br = BASE_RED; bg = 0; bb = 0;
        end
        else
        begin
            br = BASE_WHITE; bg = BASE_WHITE; bb = BASE_WHITE;
        end
        num = 256 * rr + zq;
        den = 512 * rr;
        pc.on_sphere = 1'b1;
        pc.r = CHAN_W'((br * num) / den);
        pc.g = CHAN_W'((bg * num) / den);
        pc.b = CHAN_W'((bb * num) / den);
        return pc;
    endfunction

    assign pending_pixels = expected_colors.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_color_t want;
        pixel_color_t got;
        if (!rst_n)
        begin
            radius_q   <= RADIUS_RST;
            tilt_cos_q <= TILT_COS_RST;
            tilt_sin_q <= TILT_SIN_RST;
            spin_cos_q <= SPIN_COS_RST;
            spin_sin_q <= SPIN_SIN_RST;
            fail_count <= 0;
            expected_colors.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_colors.push_back(shade_pixel(pixel_col, pixel_row));
            if (out_valid && out_ready)
            begin
                got = '{inside_res, red, green, blue};
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected color %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (want !== got)
                    begin
                        $display("%0t: color mismatch expected %h actual %h",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RADIUS:   radius_q   <= cfg_data[RADIUS_W-1:0];
                    REG_TILT_COS: tilt_cos_q <= cfg_data;
                    REG_TILT_SIN: tilt_sin_q <= cfg_data;
                    REG_SPIN_COS: spin_cos_q <= cfg_data;
                    REG_SPIN_SIN: spin_sin_q <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/checkered_sphere_shader_top_tb.sv */
`timescale 1ns / 100ps

module checkered_sphere_shader_top_tb;
    import csph_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_col = '0;
    logic [PIX_W-1:0]      pixel_row = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  inside_res;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending_pixels;
    bit                    quiet_phase = 1'b0;
    int                    cur_radius = 100;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    checkered_sphere_shader_top dut (.*);

    checkered_sphere_shader_checker color_check (.*);

    always @(posedge clk)
    begin
        if (quiet_phase || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            out_ready <= 1'b1;
        end
    end

    task automatic send_pixel(int c, int w);
        cfg_valid <= 1'b0;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pixel_col <= c[PIX_W-1:0];
        pixel_row <= w[PIX_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(int idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_RADIUS)
            cur_radius = val & 8'hff;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_trig(int idx);
        case ($urandom_range(0, 4))
            0: write_reg(idx, 16384);
            1: write_reg(idx, -16384);
            2: write_reg(idx, 0);
            3: write_reg(idx, $urandom());
            default: write_reg(idx, $urandom_range(0, 32768) - 16384);
        endcase
    endtask

    task automatic random_pixels(int n);
        int lim;
        for (int i = 0; i < n; i++)
        begin
            lim = (cur_radius == 0) ? 255 : 2 * cur_radius - 1;
            if (lim > 255)
                lim = 255;
            if ($urandom_range(0, 9) == 0)
                send_pixel($urandom_range(0, 255), $urandom_range(0, 255));
            else
                send_pixel($urandom_range(0, lim), $urandom_range(0, lim));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pixel(100, 100);
        send_pixel(0, 0);
        send_pixel(199, 100);
        send_pixel(100, 0);
        send_pixel(100, 199);
        send_pixel(0, 100);
        send_pixel(200, 100);
        send_pixel(255, 255);
        send_pixel(130, 60);
        send_pixel(70, 140);
        drain();
        write_reg(REG_RADIUS, 128);
        write_reg(REG_TILT_COS, 16384);
        write_reg(REG_TILT_SIN, 0);
        write_reg(REG_SPIN_COS, -16384);
        write_reg(REG_SPIN_SIN, 16384);
        write_reg(5, 123);
        send_pixel(0, 128);
        send_pixel(255, 128);
        send_pixel(128, 128);
        send_pixel(128, 0);
        send_pixel(128, 255);
        drain();
        write_reg(REG_RADIUS, 255);
        send_pixel(255, 255);
        send_pixel(128, 128);
        drain();
        write_reg(REG_RADIUS, 0);
        send_pixel(0, 0);
        drain();
        write_reg(REG_RADIUS, 1);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(0, 1);
        drain();
        write_reg(REG_TILT_COS, 32767);
        write_reg(REG_TILT_SIN, -32768);
        write_reg(REG_RADIUS, 40);
        random_pixels(20);
        drain();
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_RADIUS, $urandom_range(1, 8));
                1: write_reg(REG_RADIUS, $urandom_range(0, 255));
                default: write_reg(REG_RADIUS, $urandom_range(1, 128));
            endcase
            for (int r = REG_TILT_COS; r <= REG_SPIN_SIN; r++)
                random_trig(r);
            if (ph == 9)
                quiet_phase = 1'b1;
            random_pixels(100);
            drain();
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

/* checkered_sphere_shader_top.f */
rtl/csph_pkg.sv
rtl/csph_sqrt.sv
rtl/csph_cordic.sv
rtl/checkered_sphere_shader_top.sv
tb/checkered_sphere_shader_checker.sv
tb/checkered_sphere_shader_top_tb.sv
